[sv/aspd_pkg.sv]
`default_nettype none
package aspd_pkg;

    localparam int SHORT_WINDOW = 5;
    localparam int LONG_WINDOW  = 10;
    localparam int COUNTER_BITS = 32;

    localparam int SHORT_IDX_W  = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
    localparam int LONG_IDX_W   = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;
    localparam int SHORT_FILL_W = $clog2(SHORT_WINDOW + 1);
    localparam int LONG_FILL_W  = $clog2(LONG_WINDOW + 1);

    localparam int CPR_W    = 21;
    localparam int DIV_BITS = 58;
    localparam int DEN_BITS = 37;
    localparam int DCNT_W   = $clog2(DIV_BITS);

    localparam logic [25:0]      MRPM_SCALE = 26'd60000000;
    localparam logic [CPR_W-1:0] MAX_CPR    = 21'd1048576;

    localparam logic [2:0] CFG_CPR       = 3'd0;
    localparam logic [2:0] CFG_INVERT    = 3'd1;
    localparam logic [2:0] CFG_MIN_DELTA = 3'd2;
    localparam logic [2:0] CFG_MAX_WIN   = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd4;
    localparam logic [2:0] CFG_FILTER_TC = 3'd5;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SET_ZERO = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] counter_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] logical_pos;
        logic        [19:0] rev_offset;
        logic signed [31:0] tick_delta;
        logic signed [31:0] window_delta;
        logic        [15:0] measurement_period;
        logic signed [31:0] window_speed;
        logic signed [31:0] smoothed_speed;
        logic               speed_ready;
        logic signed [31:0] short_window_speed_mrpm;
        logic signed [31:0] long_window_speed_mrpm;
    } out_item_t;

    function automatic logic [31:0] sext_counter(input logic [31:0] v);
        logic [31:0] m;
        logic [31:0] r;
        m = 32'hFFFF_FFFF >> (32 - COUNTER_BITS);
        r = v & m;
        if (r[COUNTER_BITS-1])
        begin
            r = r | ~m;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [58:0] x);
        if (x > 59'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < -59'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

[sv/aspd_div.sv]
`default_nettype none
module aspd_div
    import aspd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DIV_BITS-1:0] dividend,
    input  wire logic [DEN_BITS-1:0] divisor,
    output logic                     busy,
    output logic                     done,
    output logic [DIV_BITS-1:0]      quotient,
    output logic [DEN_BITS-1:0]      remainder
);

    logic [DEN_BITS-1:0] rem_reg;
    logic [DIV_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] dvs_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DEN_BITS:0]   trial;
    logic                ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[DIV_BITS-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= DCNT_W'(DIV_BITS - 1);
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? DEN_BITS'(trial - {1'b0, dvs_reg}) : trial[DEN_BITS-1:0];
                quo_reg  <= {quo_reg[DIV_BITS-2:0], ge};
                done_reg <= (cnt_reg == '0);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

[sv/encoder_adaptive_speed_estimator_top.sv]
`default_nettype none
// Encoder position and adaptive-window speed estimator.
// Input channel in_valid/in_stall/in_data carries one item per millisecond tick
// (op = tick) or a set-zero request (op = set-zero) with the sampled counter.
// Output channel out_valid/out_stall/out_data returns exactly one result item
// per input item, in order. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is
// idle, as the block itself does not enforce this. Each item is worked by
// a sequencer around one shared 58-bit restoring divider that retires one
// quotient bit per cycle. A set-zero or an unarmed tick runs one job
// (revolution remainder), an armed tick runs three jobs and a tick that
// closes the adaptive window runs five. in_stall stays high from the accept
// until the result is moved to the output register.
// The finished result sits in an output register; while out_stall holds it,
// the block keeps the next result in its sequencer and takes no new item.
// Reset clears all speed state, loads the default configuration and leaves
// the block unarmed: ticks report position but change no state until the
// first set-zero item arms it.
module encoder_adaptive_speed_estimator_top
    import aspd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [20:0] cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_SETUP, S_RUN, S_OUT} state_t;
    typedef enum logic [2:0] {J_REV, J_SHORT, J_LONG, J_RAW, J_FILT} job_t;

    state_t state_reg;
    job_t   job_reg;

    // configuration
    logic [CPR_W-1:0] cpr_reg;
    logic             invert_reg;
    logic [15:0]      min_delta_reg;
    logic [15:0]      max_win_reg;
    logic [15:0]      timeout_reg;
    logic [15:0]      filter_tc_reg;

    // estimator state
    logic               armed_reg;
    logic [31:0]        zero_point_reg;
    logic [31:0]        last_position_reg;
    logic [31:0]        accumulated_reg;
    logic signed [31:0] last_measured_reg;
    logic signed [31:0] raw_speed_reg;
    logic signed [31:0] filtered_reg;
    logic [15:0]        window_reg;
    logic [15:0]        still_reg;
    logic [15:0]        period_reg;
    logic               valid_flag_reg;
    logic [31:0]        last_delta_reg;
    logic [31:0]        short_ring_reg [SHORT_WINDOW];
    logic [31:0]        long_ring_reg  [LONG_WINDOW];
    logic [31:0]        short_sum_reg;
    logic [31:0]        long_sum_reg;
    logic [SHORT_IDX_W-1:0]  short_idx_reg;
    logic [LONG_IDX_W-1:0]   long_idx_reg;
    logic [SHORT_FILL_W-1:0] short_fill_reg;
    logic [LONG_FILL_W-1:0]  long_fill_reg;
    logic signed [31:0] short_speed_reg;
    logic signed [31:0] long_speed_reg;

    // per-item working registers
    logic [31:0]        pos_reg;
    logic [19:0]        rev_reg;
    logic               run_reg;
    logic               close_reg;
    logic [15:0]        close_win_reg;
    logic [DIV_BITS-1:0] num_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic               neg_reg;
    logic               start_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic in_accept;
    logic out_free;

    // effective revolution count: zero acts as one, clamp at the maximum
    logic [CPR_W-1:0] cpr_eff;
    always_comb
    begin
        if (cpr_reg == '0)
        begin
            cpr_eff = CPR_W'(1);
        end
        else if (cpr_reg > MAX_CPR)
        begin
            cpr_eff = MAX_CPR;
        end
        else
        begin
            cpr_eff = cpr_reg;
        end
    end

    // tick arithmetic, all evaluated in the accept cycle
    logic [31:0] pos_raw;
    logic [31:0] pos_now;
    logic [31:0] delta;
    logic [31:0] short_sum_new;
    logic [31:0] long_sum_new;
    logic [31:0] acc_new;
    logic [31:0] acc_mag;
    logic [15:0] win_new;
    logic [15:0] still_new;
    logic        timeout_hit;
    logic        window_close;

    always_comb
    begin
        pos_raw       = sext_counter(in_data.counter_value - zero_point_reg);
        pos_now       = invert_reg ? (32'd0 - pos_raw) : pos_raw;
        delta         = sext_counter(pos_now - last_position_reg);
        short_sum_new = short_sum_reg - short_ring_reg[short_idx_reg] + delta;
        long_sum_new  = long_sum_reg - long_ring_reg[long_idx_reg] + delta;
        acc_new       = accumulated_reg + delta;
        acc_mag       = acc_new[31] ? (32'd0 - acc_new) : acc_new;
        win_new       = (window_reg == 16'hFFFF) ? window_reg : window_reg + 16'd1;
        if (delta != '0)
        begin
            still_new = '0;
        end
        else
        begin
            still_new = (still_reg == 16'hFFFF) ? still_reg : still_reg + 16'd1;
        end
        timeout_hit  = (still_new >= timeout_reg);
        window_close = !timeout_hit &&
                       !((acc_mag < {16'd0, min_delta_reg}) && (win_new < max_win_reg));
    end

    // operand selection for the shared divider
    logic signed [33:0] num_base;
    logic [25:0]        num_scale;
    logic [15:0]        den_ticks;
    logic [32:0]        num_mag;
    logic [58:0]        num_prod;
    logic [DEN_BITS-1:0] den_prod;

    always_comb
    begin
        num_base  = {{2{pos_reg[31]}}, pos_reg};
        num_scale = 26'd1;
        den_ticks = 16'd1;
        case (job_reg)
            J_REV:
            begin
                num_base  = {{2{pos_reg[31]}}, pos_reg};
                num_scale = 26'd1;
                den_ticks = 16'd1;
            end
            J_SHORT:
            begin
                num_base  = {{2{short_sum_reg[31]}}, short_sum_reg};
                num_scale = MRPM_SCALE;
                den_ticks = 16'(short_fill_reg);
            end
            J_LONG:
            begin
                num_base  = {{2{long_sum_reg[31]}}, long_sum_reg};
                num_scale = MRPM_SCALE;
                den_ticks = 16'(long_fill_reg);
            end
            J_RAW:
            begin
                num_base  = {{2{last_measured_reg[31]}}, last_measured_reg};
                num_scale = MRPM_SCALE;
                den_ticks = close_win_reg;
            end
            J_FILT:
            begin
                num_base  = {{2{raw_speed_reg[31]}}, raw_speed_reg}
                          - {{2{filtered_reg[31]}}, filtered_reg};
                num_scale = {10'd0, close_win_reg};
                den_ticks = 16'd1;
            end
            default:
            begin
                num_base  = '0;
                num_scale = 26'd1;
                den_ticks = 16'd1;
            end
        endcase
        num_mag  = num_base[33] ? 33'(-num_base) : num_base[32:0];
        num_prod = num_mag * num_scale;
        if (job_reg == J_FILT)
        begin
            den_prod = DEN_BITS'({1'b0, filter_tc_reg} + {1'b0, close_win_reg});
        end
        else
        begin
            den_prod = cpr_eff * den_ticks;
        end
    end

    logic                div_busy;
    logic                div_done;
    logic [DIV_BITS-1:0] div_quot;
    logic [DEN_BITS-1:0] div_rem;

    aspd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (num_reg),
        .divisor   (den_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // signed quotient, remainder-derived revolution count, filter sum
    logic signed [58:0] quot_s;
    logic signed [58:0] filt_sum;
    logic [CPR_W-1:0]   rem_small;
    logic [CPR_W-1:0]   rev_calc;

    always_comb
    begin
        quot_s    = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        filt_sum  = {{27{filtered_reg[31]}}, filtered_reg} + quot_s;
        rem_small = div_rem[CPR_W-1:0];
        rev_calc  = (neg_reg && (rem_small != '0)) ? (cpr_eff - rem_small) : rem_small;
    end

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            job_reg           <= J_REV;
            cpr_reg           <= 21'd4096;
            invert_reg        <= 1'b0;
            min_delta_reg     <= 16'd4;
            max_win_reg       <= 16'd20;
            timeout_reg       <= 16'd100;
            filter_tc_reg     <= 16'd4;
            armed_reg         <= 1'b0;
            zero_point_reg    <= '0;
            last_position_reg <= '0;
            accumulated_reg   <= '0;
            last_measured_reg <= '0;
            raw_speed_reg     <= '0;
            filtered_reg      <= '0;
            window_reg        <= '0;
            still_reg         <= '0;
            period_reg        <= '0;
            valid_flag_reg    <= 1'b0;
            last_delta_reg    <= '0;
            short_ring_reg    <= '{default: '0};
            long_ring_reg     <= '{default: '0};
            short_sum_reg     <= '0;
            long_sum_reg      <= '0;
            short_idx_reg     <= '0;
            long_idx_reg      <= '0;
            short_fill_reg    <= '0;
            long_fill_reg     <= '0;
            short_speed_reg   <= '0;
            long_speed_reg    <= '0;
            pos_reg           <= '0;
            rev_reg           <= '0;
            run_reg           <= 1'b0;
            close_reg         <= 1'b0;
            close_win_reg     <= '0;
            num_reg           <= '0;
            den_reg           <= '0;
            neg_reg           <= 1'b0;
            start_reg         <= 1'b0;
            out_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            // launch the divider in the cycle after operand setup
            start_reg <= (state_reg == S_SETUP);

            // raise valid with a new result, drop it once the result is taken
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CPR:       cpr_reg       <= cfg_data;
                    CFG_INVERT:    invert_reg    <= cfg_data[0];
                    CFG_MIN_DELTA: min_delta_reg <= cfg_data[15:0];
                    CFG_MAX_WIN:   max_win_reg   <= cfg_data[15:0];
                    CFG_TIMEOUT:   timeout_reg   <= cfg_data[15:0];
                    CFG_FILTER_TC: filter_tc_reg <= cfg_data[15:0];
                    default:       ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        job_reg   <= J_REV;
                        state_reg <= S_SETUP;
                        close_reg <= (in_data.op == OP_TICK) && armed_reg && window_close;
                        if (in_data.op == OP_SET_ZERO)
                        begin
                            // capture zero and clear every piece of speed state
                            zero_point_reg    <= in_data.counter_value
                                              & (32'hFFFF_FFFF >> (32 - COUNTER_BITS));
                            armed_reg         <= 1'b1;
                            pos_reg           <= '0;
                            run_reg           <= 1'b0;
                            last_position_reg <= '0;
                            accumulated_reg   <= '0;
                            last_delta_reg    <= '0;
                            last_measured_reg <= '0;
                            raw_speed_reg     <= '0;
                            filtered_reg      <= '0;
                            short_speed_reg   <= '0;
                            long_speed_reg    <= '0;
                            window_reg        <= '0;
                            still_reg         <= '0;
                            period_reg        <= '0;
                            valid_flag_reg    <= 1'b0;
                            short_ring_reg    <= '{default: '0};
                            long_ring_reg     <= '{default: '0};
                            short_sum_reg     <= '0;
                            long_sum_reg      <= '0;
                            short_idx_reg     <= '0;
                            long_idx_reg      <= '0;
                            short_fill_reg    <= '0;
                            long_fill_reg     <= '0;
                        end
                        else
                        begin
                            pos_reg <= pos_now;
                            run_reg <= armed_reg;
                            if (armed_reg)
                            begin
                                last_position_reg <= pos_now;
                                last_delta_reg    <= delta;
                                short_ring_reg[short_idx_reg] <= delta;
                                long_ring_reg[long_idx_reg]   <= delta;
                                short_sum_reg <= short_sum_new;
                                long_sum_reg  <= long_sum_new;
                                short_idx_reg <= (int'(short_idx_reg) + 1 >= SHORT_WINDOW)
                                               ? '0 : short_idx_reg + 1'b1;
                                long_idx_reg  <= (int'(long_idx_reg) + 1 >= LONG_WINDOW)
                                               ? '0 : long_idx_reg + 1'b1;
                                if (short_fill_reg < SHORT_FILL_W'(SHORT_WINDOW))
                                begin
                                    short_fill_reg <= short_fill_reg + 1'b1;
                                end
                                if (long_fill_reg < LONG_FILL_W'(LONG_WINDOW))
                                begin
                                    long_fill_reg <= long_fill_reg + 1'b1;
                                end
                                still_reg <= still_new;
                                if (timeout_hit)
                                begin
                                    // no motion: force zero speed
                                    accumulated_reg   <= '0;
                                    last_measured_reg <= '0;
                                    raw_speed_reg     <= '0;
                                    filtered_reg      <= '0;
                                    window_reg        <= '0;
                                    period_reg        <= timeout_reg;
                                    valid_flag_reg    <= 1'b1;
                                end
                                else if (window_close)
                                begin
                                    last_measured_reg <= acc_new;
                                    period_reg        <= win_new;
                                    close_win_reg     <= win_new;
                                    accumulated_reg   <= '0;
                                    window_reg        <= '0;
                                    valid_flag_reg    <= 1'b1;
                                end
                                else
                                begin
                                    accumulated_reg <= acc_new;
                                    window_reg      <= win_new;
                                end
                            end
                        end
                    end
                end

                S_SETUP:
                begin
                    // register operands; the divider starts next cycle
                    num_reg   <= num_prod[DIV_BITS-1:0];
                    den_reg   <= den_prod;
                    neg_reg   <= num_base[33];
                    state_reg <= S_RUN;
                end

                S_RUN:
                begin
                    if (div_done)
                    begin
                        case (job_reg)
                            J_REV:
                            begin
                                rev_reg <= rev_calc[19:0];
                                if (run_reg)
                                begin
                                    job_reg   <= J_SHORT;
                                    state_reg <= S_SETUP;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            J_SHORT:
                            begin
                                short_speed_reg <= sat32(quot_s);
                                job_reg         <= J_LONG;
                                state_reg       <= S_SETUP;
                            end
                            J_LONG:
                            begin
                                long_speed_reg <= sat32(quot_s);
                                if (close_reg)
                                begin
                                    job_reg   <= J_RAW;
                                    state_reg <= S_SETUP;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            J_RAW:
                            begin
                                raw_speed_reg <= sat32(quot_s);
                                job_reg       <= J_FILT;
                                state_reg     <= S_SETUP;
                            end
                            J_FILT:
                            begin
                                filtered_reg <= sat32(filt_sum);
                                state_reg    <= S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end

                S_OUT:
                begin
                    // hold the result until the output register frees up
                    if (out_free)
                    begin
                        out_reg.logical_pos             <= pos_reg;
                        out_reg.rev_offset              <= rev_reg;
                        out_reg.tick_delta              <= last_delta_reg;
                        out_reg.window_delta            <= last_measured_reg;
                        out_reg.measurement_period      <= period_reg;
                        out_reg.window_speed            <= raw_speed_reg;
                        out_reg.smoothed_speed          <= filtered_reg;
                        out_reg.speed_ready             <= valid_flag_reg;
                        out_reg.short_window_speed_mrpm <= short_speed_reg;
                        out_reg.long_window_speed_mrpm  <= long_speed_reg;
                        state_reg                       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // once armed, only reset disarms the block
    a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(armed_reg))
        else $error("armed flag dropped without reset");

    // the divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_RUN))
        else $error("divider busy outside run state");

    // a new result always carries a revolution count below the effective cpr
    a_rev_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ({1'b0, out_reg.rev_offset} < cpr_eff))
        else $error("count in revolution out of range");

    // a set-zero item leaves the speed state cleared for its result
    a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_data.op == OP_SET_ZERO)) |=> (!valid_flag_reg && (pos_reg == '0)))
        else $error("set-zero did not clear state");
`endif

endmodule
`default_nettype wire
